// ===== src/c2d_pkg.sv =====
// Shared constants, types and helpers for the zero-padded 2D convolution stream.
package c2d_pkg;

	localparam int MAX_COLS   = 1024;
	localparam int MAX_ROWS   = 4096;
	localparam int MAX_KERNEL = 5;

	localparam int COL_AW  = $clog2(MAX_COLS);
	localparam int SLOT_W  = $clog2(MAX_KERNEL);
	localparam int KW      = $clog2(MAX_KERNEL + 1);
	localparam int ROWS_W  = 13;
	localparam int COLS_W  = 11;
	localparam int SHAPE_W = 5;
	localparam int COEF_W  = 12;
	localparam int CFG_W   = 60;
	localparam int IDX_W   = 3;
	localparam int PIX_W   = 8;
	localparam int PROD_W  = 20;
	localparam int RSUM_W  = PROD_W + 3;
	localparam int TSUM_W  = RSUM_W + 3;
	localparam int OUT_W   = 19;
	localparam int OUT_MAX = 2 ** (OUT_W - 1) - 1;
	localparam int OUT_MIN = -(2 ** (OUT_W - 1));

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [RSUM_W-1:0] rsum_t;

	typedef enum logic [IDX_W-1:0] {
		REG_IMAGE_ROWS,
		REG_IMAGE_COLS,
		REG_KERNEL_SHAPE,
		REG_COEF_A,
		REG_COEF_B,
		REG_COEF_C,
		REG_COEF_D,
		REG_COEF_E
	} cfg_reg_t;

	// Sideband that travels with each item down the pipeline.
	typedef struct packed {
		logic valid;
		logic emit;
		logic last;
	} tag_t;

	typedef struct packed {
		logic [KW-1:0] kr;
		logic [KW-1:0] kc;
	} kdim_t;

	// Decode (kr-1)*5 + (kc-1); codes above 24 act as a full 5x5 kernel.
	function automatic kdim_t kernel_dims(input logic [SHAPE_W-1:0] shape);
		logic [SHAPE_W-1:0] s;
		logic [2:0]         q;
		kdim_t              d;
		s = (shape > SHAPE_W'(24)) ? SHAPE_W'(24) : shape;
		if (s >= SHAPE_W'(20))
			q = 3'd4;
		else if (s >= SHAPE_W'(15))
			q = 3'd3;
		else if (s >= SHAPE_W'(10))
			q = 3'd2;
		else if (s >= SHAPE_W'(5))
			q = 3'd1;
		else
			q = 3'd0;
		d.kr = KW'(q) + KW'(1);
		d.kc = KW'(s - {2'b00, q} * SHAPE_W'(5)) + KW'(1);
		return d;
	endfunction

endpackage

// ===== src/c2d_linebuf.sv =====
// Line store: one row memory per slot, row r lives in slot r mod MAX_KERNEL.
module c2d_linebuf import c2d_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [SLOT_W-1:0] wslot,
	input  logic [COL_AW-1:0] addr,
	input  pix_t              wdata,
	input  logic              re,
	output pix_t              rdata [MAX_KERNEL]
);

	for (genvar g = 0; g < MAX_KERNEL; g++) begin : g_slot
		pix_t mem [MAX_COLS];

		always_ff @(posedge clk) begin
			if (we && wslot == SLOT_W'(g)) begin
				mem[addr] <= wdata;
			end
			if (re) begin
				rdata[g] <= mem[addr];
			end
		end
	end

endmodule

// ===== src/c2d_mac.sv =====
// Tap products (s3) and per-row partial sums (s4) of the 5x5 window.
module c2d_mac import c2d_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  tag_t  tag_s2,
	input  pix_t  win_s2 [MAX_KERNEL][MAX_KERNEL],
	input  coef_t coef [MAX_KERNEL][MAX_KERNEL],
	output tag_t  tag_s4,
	output rsum_t rsum_s4 [MAX_KERNEL]
);

	tag_t                     tag_s3;
	logic signed [PROD_W-1:0] prod_s3 [MAX_KERNEL][MAX_KERNEL];
	rsum_t                    rsum_d [MAX_KERNEL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else if (en) begin
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < MAX_KERNEL; a++) begin
				for (int b = 0; b < MAX_KERNEL; b++) begin
					prod_s3[a][b] <= PROD_W'($signed({1'b0, win_s2[a][b]}) * coef[a][b]);
				end
				rsum_s4[a] <= rsum_d[a];
			end
		end
	end

	always_comb begin
		for (int a = 0; a < MAX_KERNEL; a++) begin
			rsum_d[a] = '0;
			for (int b = 0; b < MAX_KERNEL; b++) begin
				rsum_d[a] = rsum_d[a] + RSUM_W'(prod_s3[a][b]);
			end
		end
	end

endmodule

// ===== src/conv2d_zero_padded_stream.sv =====
// Top level of the zero-padded streaming 2D convolution.
//
//   channel  signals                             role
//   input    in_valid, in_ready, pixel           one pixel per virtual raster position
//   output   out_valid, out_ready, conv_value,   one sum per image pixel
//            frame_last
//   config   cfg_we, cfg_index, cfg_data         register writes, no wait state
//
// One pixel per clock while the output is not stalled; an accepted transaction passes
// through the input/line-store read, window, products, row sums and total stages.
// Reset puts the position counters at the frame origin and restores the
// register defaults; the line store is not cleared and needs no clearing pass.
// A stalled output freezes the whole pipeline and drops in_ready.
module conv2d_zero_padded_stream import c2d_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [PIX_W-1:0]         pixel,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [OUT_W-1:0]  conv_value,
	output logic                     frame_last,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]         cfg_data
);

	localparam int K = MAX_KERNEL;

	// configuration
	logic [ROWS_W-1:0]  rows_q;
	logic [COLS_W-1:0]  cols_q;
	logic [SHAPE_W-1:0] shape_q;
	logic [CFG_W-1:0]   coef_q [K];
	coef_t              eff_coef_q [K][K];

	logic [ROWS_W-1:0]  rows_eff;
	logic [COLS_W-1:0]  cols_eff;
	logic [ROWS_W-1:0]  vrows;
	logic [COLS_W-1:0]  vcols;
	kdim_t              kd;

	// position
	logic [ROWS_W-1:0]  vr_q;
	logic [COLS_W-1:0]  vc_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [COLS_W:0]    vc_inc;
	logic [ROWS_W:0]    vr_inc;
	logic               col_wrap;
	logic               row_wrap;
	logic               acc;
	logic               en;
	logic               col_in;
	logic               row_ok [K];
	tag_t               tag_d;

	// pipeline
	tag_t               tag_s1;
	pix_t               pix_s1;
	logic               colin_s1;
	logic               rowok_s1 [K];
	logic [SLOT_W-1:0]  slot_s1;
	pix_t               rdata_s1 [K];
	pix_t               col_new [K];
	tag_t               tag_s2;
	pix_t               win_s2 [K][K];
	tag_t               tag_s4;
	rsum_t              rsum_s4 [K];
	logic signed [TSUM_W-1:0] total;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign acc      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= ROWS_W'(1);
			cols_q  <= COLS_W'(1);
			shape_q <= SHAPE_W'(24);
			for (int i = 0; i < K; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_ROWS:   rows_q    <= cfg_data[ROWS_W-1:0];
				REG_IMAGE_COLS:   cols_q    <= cfg_data[COLS_W-1:0];
				REG_KERNEL_SHAPE: shape_q   <= cfg_data[SHAPE_W-1:0];
				REG_COEF_A:       coef_q[0] <= cfg_data;
				REG_COEF_B:       coef_q[1] <= cfg_data;
				REG_COEF_C:       coef_q[2] <= cfg_data;
				REG_COEF_D:       coef_q[3] <= cfg_data;
				REG_COEF_E:       coef_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (rows_q == '0)
			rows_eff = ROWS_W'(1);
		else if (rows_q > ROWS_W'(MAX_ROWS))
			rows_eff = ROWS_W'(MAX_ROWS);
		else
			rows_eff = rows_q;
		if (cols_q == '0)
			cols_eff = COLS_W'(1);
		else if (cols_q > COLS_W'(MAX_COLS))
			cols_eff = COLS_W'(MAX_COLS);
		else
			cols_eff = cols_q;
		kd    = kernel_dims(shape_q);
		vrows = rows_eff + ROWS_W'(kd.kr) - ROWS_W'(1);
		vcols = cols_eff + COLS_W'(kd.kc) - COLS_W'(1);
	end

	// Window position (a,b) = (row age, column age); tap (kr-1-a, kc-1-b).
	always_ff @(posedge clk) begin
		for (int a = 0; a < K; a++) begin
			for (int b = 0; b < K; b++) begin
				if (a < int'(kd.kr) && b < int'(kd.kc)) begin
					eff_coef_q[a][b] <=
						coef_q[SLOT_W'(int'(kd.kr) - 1 - a)][(int'(kd.kc) - 1 - b) * COEF_W +: COEF_W];
				end else begin
					eff_coef_q[a][b] <= '0;
				end
			end
		end
	end

	// position decode for the incoming transaction
	always_comb begin
		vc_inc   = {1'b0, vc_q} + (COLS_W+1)'(1);
		vr_inc   = {1'b0, vr_q} + (ROWS_W+1)'(1);
		col_wrap = vc_inc >= {1'b0, vcols};
		row_wrap = vr_inc >= {1'b0, vrows};
		col_in   = vc_q < cols_eff;
		for (int a = 0; a < K; a++) begin
			row_ok[a] = (vr_q >= ROWS_W'(a)) &&
				({1'b0, vr_q} < {1'b0, rows_eff} + (ROWS_W+1)'(a)) &&
				(a < int'(kd.kr));
		end
		tag_d.valid = 1'b1;
		tag_d.emit  = (vr_q < vrows) && (vc_q < vcols) &&
			(vr_q >= ROWS_W'(kd.kr) - ROWS_W'(1)) && (vc_q >= COLS_W'(kd.kc) - COLS_W'(1));
		tag_d.last  = (vr_q == vrows - ROWS_W'(1)) && (vc_q == vcols - COLS_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vr_q   <= '0;
			vc_q   <= '0;
			slot_q <= '0;
		end else if (acc) begin
			if (col_wrap) begin
				vc_q <= '0;
				if (row_wrap) begin
					vr_q   <= '0;
					slot_q <= '0;
				end else begin
					vr_q   <= vr_q + ROWS_W'(1);
					slot_q <= (slot_q == SLOT_W'(K - 1)) ? '0 : slot_q + SLOT_W'(1);
				end
			end else begin
				vc_q <= vc_q + COLS_W'(1);
			end
		end
	end

	c2d_linebuf u_linebuf (
		.clk   (clk),
		.we    (acc && col_in && row_ok[0]),
		.wslot (slot_q),
		.addr  (vc_q[COL_AW-1:0]),
		.wdata (pixel),
		.re    (acc),
		.rdata (rdata_s1)
	);

	// s1: input register alongside the line-store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (en) begin
			tag_s1 <= acc ? tag_d : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1   <= pixel;
			colin_s1 <= col_in;
			rowok_s1 <= row_ok;
			slot_s1  <= slot_q;
		end
	end

	// Column entering the window; taps outside the image read as zero.
	always_comb begin
		for (int a = 0; a < K; a++) begin
			if (!(colin_s1 && rowok_s1[a])) begin
				col_new[a] = '0;
			end else if (a == 0) begin
				col_new[a] = pix_s1;
			end else if (slot_s1 >= SLOT_W'(a)) begin
				col_new[a] = rdata_s1[slot_s1 - SLOT_W'(a)];
			end else begin
				col_new[a] = rdata_s1[slot_s1 + SLOT_W'(K - a)];
			end
		end
	end

	// s2: window, shifted once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			for (int a = 0; a < K; a++) begin
				for (int b = 0; b < K; b++) begin
					win_s2[a][b] <= '0;
				end
			end
		end else if (en) begin
			tag_s2 <= tag_s1;
			if (tag_s1.valid) begin
				for (int a = 0; a < K; a++) begin
					win_s2[a][0] <= col_new[a];
					for (int b = 1; b < K; b++) begin
						win_s2[a][b] <= win_s2[a][b-1];
					end
				end
			end
		end
	end

	c2d_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.tag_s2  (tag_s2),
		.win_s2  (win_s2),
		.coef    (eff_coef_q),
		.tag_s4  (tag_s4),
		.rsum_s4 (rsum_s4)
	);

	always_comb begin
		total = '0;
		for (int a = 0; a < K; a++) begin
			total = total + TSUM_W'(rsum_s4[a]);
		end
	end

	// output register, sum saturated to the field
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= tag_s4.valid && tag_s4.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en && tag_s4.valid && tag_s4.emit) begin
			frame_last <= tag_s4.last;
			if (total > TSUM_W'(OUT_MAX))
				conv_value <= OUT_W'(OUT_MAX);
			else if (total < TSUM_W'(OUT_MIN))
				conv_value <= OUT_W'(OUT_MIN);
			else
				conv_value <= OUT_W'(total);
		end
	end

`ifndef SYNTHESIS
	// last virtual position of a frame returns the counters to the origin
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && col_wrap && row_wrap) |=> (vr_q == '0 && vc_q == '0 && slot_q == '0))
		else $error("position counters did not wrap at frame end");

	a_slot_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(vr_q == '0) |-> (slot_q == '0))
		else $error("line-store slot out of step with row counter");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q < SLOT_W'(K))
		else $error("line-store slot beyond kernel depth");

	a_emit_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(en && tag_s4.valid && tag_s4.emit) |=> out_valid)
		else $error("result transaction lost before output register");
`endif

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the zero-padded streaming 2D convolution.
`timescale 1ns / 100ps

module tb;
	import c2d_pkg::*;

	localparam int LAST_SHAPE   = 24;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 3000;
	localparam int MAX_REPORTS  = 10;
	localparam int RANDOM_ITEMS = 250;

	typedef enum int {PIX_RANDOM, PIX_ZERO, PIX_FULL, PIX_EXTREME} pix_mode_t;

	typedef struct {
		logic signed [OUT_W-1:0] value;
		logic                    last;
	} conv_result_t;

	typedef logic [MAX_KERNEL-1:0][CFG_W-1:0] kernel_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid;
	logic                    in_ready;
	logic [PIX_W-1:0]        pixel;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [OUT_W-1:0] conv_value;
	logic                    frame_last;
	logic                    cfg_we;
	logic [IDX_W-1:0]        cfg_index;
	logic [CFG_W-1:0]        cfg_data;

	// predictor state
	logic [ROWS_W-1:0]  model_rows = ROWS_W'(1);
	logic [COLS_W-1:0]  model_cols = COLS_W'(1);
	logic [SHAPE_W-1:0] model_shape = SHAPE_W'(LAST_SHAPE);
	kernel_t            model_coef = '0;
	pix_t               row_history [MAX_KERNEL][MAX_COLS];
	int                 pos_row = 0;
	int                 pos_col = 0;

	conv_result_t pending_sums [$];
	int           items_sent = 0;
	int           fail_count = 0;
	int           src_idle_pct = 0;
	int           sink_idle_pct = 0;
	int           sink_hold = 0;
	int           quiet_cycles = 0;

	conv2d_zero_padded_stream u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel      (pixel),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.conv_value (conv_value),
		.frame_last (frame_last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// Effective image and kernel size after clamping of the raw register values.
	function automatic void frame_geometry(output int rows, output int cols,
			output int kr, output int kc);
		int s;
		rows = (model_rows == 0) ? 1 : ((model_rows > MAX_ROWS) ? MAX_ROWS : int'(model_rows));
		cols = (model_cols == 0) ? 1 : ((model_cols > MAX_COLS) ? MAX_COLS : int'(model_cols));
		s = (model_shape > LAST_SHAPE) ? LAST_SHAPE : int'(model_shape);
		kr = s / MAX_KERNEL + 1;
		kc = s % MAX_KERNEL + 1;
	endfunction

	function automatic void conv_predict(input pix_t p, output bit hit, output conv_result_t res);
		int     rows, cols, kr, kc, r, c, ir, ic, ki, kj;
		longint acc;
		coef_t  w;
		pix_t   tap;
		frame_geometry(rows, cols, kr, kc);
		hit = 1'b0;
		res.value = '0;
		res.last = 1'b0;
		acc = 0;
		if (pos_row < rows && pos_col < cols)
			row_history[pos_row % MAX_KERNEL][pos_col] = p;
		if (pos_row >= kr - 1 && pos_col >= kc - 1 &&
				pos_row < rows + kr - 1 && pos_col < cols + kc - 1) begin
			r = pos_row - (kr - 1);
			c = pos_col - (kc - 1);
			for (ki = 0; ki < kr; ki++) begin
				for (kj = 0; kj < kc; kj++) begin
					ir = r + ki;
					ic = c + kj;
					tap = (ir < rows && ic < cols) ? row_history[ir % MAX_KERNEL][ic] : '0;
					w = model_coef[ki][COEF_W*kj +: COEF_W];
					acc += longint'(tap) * longint'(w);
				end
			end
			if (acc > OUT_MAX)
				acc = OUT_MAX;
			if (acc < OUT_MIN)
				acc = OUT_MIN;
			res.value = acc[OUT_W-1:0];
			res.last = (r == rows - 1 && c == cols - 1);
			hit = 1'b1;
		end
		pos_col++;
		if (pos_col >= cols + kc - 1) begin
			pos_col = 0;
			pos_row++;
			if (pos_row >= rows + kr - 1)
				pos_row = 0;
		end
	endfunction

	function automatic kernel_t random_kernel(input bit mild);
		kernel_t k;
		int      ki, kj;
		for (ki = 0; ki < MAX_KERNEL; ki++) begin
			k[ki] = CFG_W'({$urandom, $urandom});
			// small taps keep sums in range so unsaturated values show up
			if (mild)
				for (kj = 0; kj < MAX_KERNEL; kj++)
					k[ki][COEF_W*kj +: COEF_W] = COEF_W'($urandom_range(0, 15)) - COEF_W'(8);
		end
		return k;
	endfunction

	function automatic pix_t pick_pixel(input pix_mode_t mode);
		case (mode)
			PIX_ZERO:    return '0;
			PIX_FULL:    return '1;
			PIX_EXTREME: return $urandom_range(1) ? '1 : '0;
			default:     return pix_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int pick_idle();
		case ($urandom_range(2))
			0:       return 0;
			1:       return 10;
			default: return 40;
		endcase
	endfunction

	// Drop valid, wait for all expected sums, then let the pipeline empty.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_conv(input logic [ROWS_W-1:0] rows, input logic [COLS_W-1:0] cols,
			input logic [SHAPE_W-1:0] shape, input kernel_t coefs);
		cfg_reg_t         reg_id;
		logic [CFG_W-1:0] val;
		settle();
		reg_id = reg_id.first();
		repeat (reg_id.num()) begin
			case (reg_id)
				REG_IMAGE_ROWS:   val = CFG_W'(rows);
				REG_IMAGE_COLS:   val = CFG_W'(cols);
				REG_KERNEL_SHAPE: val = CFG_W'(shape);
				default:          val = coefs[reg_id - REG_COEF_A];
			endcase
			cfg_we <= 1'b1;
			cfg_index <= reg_id;
			cfg_data <= val;
			@(posedge clk);
			reg_id = reg_id.next();
		end
		cfg_we <= 1'b0;
		model_rows = rows;
		model_cols = cols;
		model_shape = shape;
		model_coef = coefs;
	endtask

	task automatic send_pixel(input pix_t p);
		bit           hit;
		conv_result_t res;
		if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= p;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		conv_predict(p, hit, res);
		if (hit)
			pending_sums.push_back(res);
		items_sent++;
	endtask

	task automatic send_frame(input pix_mode_t mode);
		int rows, cols, kr, kc;
		frame_geometry(rows, cols, kr, kc);
		repeat ((rows + kr - 1) * (cols + kc - 1)) send_pixel(pick_pixel(mode));
	endtask

	task automatic random_setup();
		int rows, cols, shape;
		rows = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
		cols = ($urandom_range(9) == 0) ? $urandom_range(13, 32) : $urandom_range(1, 12);
		if ($urandom_range(19) == 0)
			rows = 0;
		if ($urandom_range(19) == 0)
			cols = 0;
		shape = ($urandom_range(9) == 0) ? $urandom_range(LAST_SHAPE + 1, 31)
			: $urandom_range(0, LAST_SHAPE);
		program_conv(ROWS_W'(rows), COLS_W'(cols), SHAPE_W'(shape),
			random_kernel($urandom_range(2) == 0));
	endtask

	// 5x1 kernel on a 5x1 image: every sum overflows, both signs
	task automatic test_saturation();
		src_idle_pct = 10;
		sink_idle_pct = 10;
		program_conv(5, 1, 20, {MAX_KERNEL{{MAX_KERNEL{12'h7FF}}}});
		send_frame(PIX_FULL);
		program_conv(5, 1, 20, {MAX_KERNEL{{MAX_KERNEL{12'h800}}}});
		send_frame(PIX_FULL);
	endtask

	task automatic test_pixel_extremes();
		kernel_t k;
		k = '0;
		k[0][COEF_W-1:0] = 12'hFFF;
		k[0][2*COEF_W-1:COEF_W] = 12'h001;
		program_conv(2, 2, 1, k);
		send_frame(PIX_EXTREME);
	endtask

	// zero sizes clamp up to one, shape codes past 5x5 act as 5x5
	task automatic test_clamped_config();
		program_conv(0, 0, 31, random_kernel(1'b0));
		send_frame(PIX_RANDOM);
	endtask

	task automatic test_output_backpressure();
		src_idle_pct = 0;
		sink_idle_pct = 0;
		program_conv(6, 16, 12, random_kernel(1'b1));
		sink_hold = HOLD_CYCLES;
		send_frame(PIX_RANDOM);
	endtask

	// tall frame cycling every line-store slot, then a wide one with the full kernel
	task automatic test_largest_frames();
		src_idle_pct = 5;
		sink_idle_pct = 5;
		program_conv(24, 1, 20, random_kernel(1'b1));
		send_frame(PIX_RANDOM);
		program_conv(2, 48, LAST_SHAPE, random_kernel(1'b0));
		send_frame(PIX_RANDOM);
	endtask

	task automatic test_random_frames();
		int start;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			src_idle_pct = pick_idle();
			sink_idle_pct = pick_idle();
			random_setup();
			repeat ($urandom_range(1, 3))
				send_frame(($urandom_range(9) == 0) ? PIX_EXTREME : PIX_RANDOM);
		end
	endtask

	task automatic test_back_to_back();
		src_idle_pct = 0;
		sink_idle_pct = 0;
		repeat (3) begin
			random_setup();
			repeat (2) send_frame(PIX_RANDOM);
		end
	endtask

	initial begin : result_sink
		int n;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (sink_hold > 0) begin
				n = sink_hold;
				sink_hold = 0;
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin : result_check
		conv_result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (pending_sums.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: unexpected result conv_value %0d frame_last %b",
						$realtime, conv_value, frame_last);
			end else begin
				want = pending_sums.pop_front();
				if (conv_value !== want.value || frame_last !== want.last) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: mismatch conv_value exp %0d got %0d, frame_last exp %b got %b",
							$realtime, want.value, conv_value, want.last, frame_last);
				end
			end
		end
	end

	// counts cycles in which no transaction happens on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		in_valid <= 1'b0;
		pixel <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_IMAGE_ROWS;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_saturation();
		test_pixel_extremes();
		test_clamped_config();
		test_output_backpressure();
		test_largest_frames();
		test_random_frames();
		test_back_to_back();
		settle();
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
